/* hdl/mbht_pkg.sv */
// Package for the masked bucket hash table: sequencer states and request codes.
`timescale 1ns / 1ps

package mbht_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  localparam logic [1:0] ACT_GET   = 2'd0;
  localparam logic [1:0] ACT_PUT   = 2'd1;
  localparam logic [1:0] ACT_DEL   = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [3:0] INDEX_BITS_RESET = 4'd8;

endpackage

/* hdl/mbht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/masked_bucket_hash_table.sv */
// Top level of the masked bucket hash table: sequencer, way scan and write-back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | in_valid / in_ready       | action, lookup_key, store_value
//  out      | out_valid / out_ready     | found, read_value, overflow
//  cfg      | cfg_valid / cfg_ready     | cfg_data (index_bits)
//
// A get, put or delete scans, then writes back: one shared key comparator steps
// through the ways of the bucket, one way per cycle, off the key/value RAM read
// port, then the write-back state writes back. A clear skips the scan.
// Reset empties the table at once through one live flag per bucket; no sweep.
// The result sits in an output register; the next transaction is taken while it
// waits, and the write-back cycle holds until the output register is free.
`timescale 1ns / 1ps

module masked_bucket_hash_table #(
  parameter int MAX_INDEX_BITS = 8,
  parameter int WAYS           = 4,
  parameter int VALUE_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] lookup_key,
  input  logic [31:0]        store_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [31:0]        read_value,
  output logic               overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  localparam int NUM_BUCKETS = 1 << MAX_INDEX_BITS;
  localparam int NUM_SLOTS   = NUM_BUCKETS * WAYS;
  localparam int ADDR_W      = $clog2(NUM_SLOTS);
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  mbht_pkg::state_t state, state_next;

  logic [3:0]                index_bits;
  logic [4:0]                eff_bits;
  logic [MAX_INDEX_BITS-1:0] bucket_mask;
  logic [MAX_INDEX_BITS-1:0] bucket_in;
  logic [ADDR_W-1:0]         base_in;
  logic [NUM_BUCKETS-1:0]    row_live;

  logic [1:0]                act_q;
  logic [31:0]               key_q;
  logic [31:0]               sval_q;
  logic [MAX_INDEX_BITS-1:0] bucket_q;
  logic [ADDR_W-1:0]         base_q;
  logic                      row_live_q;
  logic [WAY_W-1:0]          way_q;
  logic                      hit_q;
  logic [WAY_W-1:0]          hit_way;
  logic [VALUE_BITS-1:0]     hit_val;
  logic                      free_q;
  logic [WAY_W-1:0]          free_way;

  logic                      accept;
  logic                      out_free;
  logic                      write_go;
  logic                      way_valid;
  logic                      key_match;

  logic [ADDR_W-1:0]         slot_raddr;
  logic [MAX_INDEX_BITS-1:0] vrow_raddr;
  logic [31:0]               key_rdata;
  logic [VALUE_BITS-1:0]     val_rdata;
  logic [WAYS-1:0]           vrow_rdata;

  logic                      key_we;
  logic                      val_we;
  logic                      vrow_we;
  logic [ADDR_W-1:0]         key_waddr;
  logic [ADDR_W-1:0]         val_waddr;
  logic [WAYS-1:0]           vrow_wdata;

  // Bucket select: clamp index_bits into 1..MAX_INDEX_BITS, then mask the key.
  always_comb begin
    if (index_bits == 4'd0) begin
      eff_bits = 5'd1;
    end else if ({1'b0, index_bits} > 5'(MAX_INDEX_BITS)) begin
      eff_bits = 5'(MAX_INDEX_BITS);
    end else begin
      eff_bits = {1'b0, index_bits};
    end
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      bucket_mask[i] = (5'(i) < eff_bits);
    end
  end

  assign bucket_in = lookup_key[MAX_INDEX_BITS-1:0] & bucket_mask;
  assign base_in   = ADDR_W'(bucket_in) * ADDR_W'(WAYS);

  assign in_ready  = (state == mbht_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;
  assign out_free  = !out_valid || out_ready;

  assign way_valid = row_live_q & vrow_rdata[way_q];
  assign key_match = (key_rdata == key_q);

  // Sequencer: next state and RAM controls.
  always_comb begin
    state_next = state;
    write_go   = 1'b0;
    slot_raddr = base_q + ADDR_W'(way_q) + ADDR_W'(1);
    vrow_raddr = bucket_q;
    key_we     = 1'b0;
    val_we     = 1'b0;
    vrow_we    = 1'b0;
    key_waddr  = base_q + ADDR_W'(free_way);
    val_waddr  = hit_q ? (base_q + ADDR_W'(hit_way)) : (base_q + ADDR_W'(free_way));
    vrow_wdata = row_live_q ? vrow_rdata : '0;

    case (state)
      mbht_pkg::ST_IDLE: begin
        slot_raddr = base_in;
        vrow_raddr = bucket_in;
        if (accept) begin
          state_next = (action == mbht_pkg::ACT_CLEAR) ? mbht_pkg::ST_WRITE
                                                       : mbht_pkg::ST_SCAN;
        end
      end
      mbht_pkg::ST_SCAN: begin
        if (way_q == LAST_WAY) begin
          state_next = mbht_pkg::ST_WRITE;
        end
      end
      mbht_pkg::ST_WRITE: begin
        if (out_free) begin
          write_go   = 1'b1;
          state_next = mbht_pkg::ST_IDLE;
          case (act_q)
            mbht_pkg::ACT_PUT: begin
              if (hit_q) begin
                val_we = 1'b1;
              end else if (free_q) begin
                key_we               = 1'b1;
                val_we               = 1'b1;
                vrow_we              = 1'b1;
                vrow_wdata[free_way] = 1'b1;
              end
            end
            mbht_pkg::ACT_DEL: begin
              if (hit_q) begin
                vrow_we             = 1'b1;
                vrow_wdata[hit_way] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = mbht_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mbht_pkg::ST_IDLE;
      index_bits <= mbht_pkg::INDEX_BITS_RESET;
      out_valid  <= 1'b0;
      row_live   <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        index_bits <= cfg_data;
      end
      if (write_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (write_go && act_q == mbht_pkg::ACT_CLEAR) begin
        row_live <= '0;
      end else if (vrow_we) begin
        row_live[bucket_q] <= 1'b1;
      end
    end
  end

  // Request context, scan results and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q      <= action;
      key_q      <= lookup_key;
      sval_q     <= store_value;
      bucket_q   <= bucket_in;
      base_q     <= base_in;
      row_live_q <= row_live[bucket_in];
      way_q      <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else if (state == mbht_pkg::ST_SCAN) begin
      way_q <= way_q + WAY_W'(1);
      // Keep the lowest matching way and the lowest free way.
      if (way_valid && key_match && !hit_q) begin
        hit_q   <= 1'b1;
        hit_way <= way_q;
        hit_val <= val_rdata;
      end
      if (!way_valid && !free_q) begin
        free_q   <= 1'b1;
        free_way <= way_q;
      end
    end
    if (write_go) begin
      found      <= (act_q != mbht_pkg::ACT_CLEAR) && hit_q;
      read_value <= (act_q == mbht_pkg::ACT_GET && hit_q) ? 32'(hit_val) : 32'd0;
      overflow   <= (act_q == mbht_pkg::ACT_PUT) && !hit_q && !free_q;
    end
  end

  mbht_ram #(
    .WIDTH (32),
    .DEPTH (NUM_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_q),
    .raddr (slot_raddr),
    .rdata (key_rdata)
  );

  mbht_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (VALUE_BITS'(sval_q)),
    .raddr (slot_raddr),
    .rdata (val_rdata)
  );

  mbht_ram #(
    .WIDTH (WAYS),
    .DEPTH (NUM_BUCKETS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vrow_we),
    .waddr (bucket_q),
    .wdata (vrow_wdata),
    .raddr (vrow_raddr),
    .rdata (vrow_rdata)
  );

endmodule

/* test/table_checker.sv */
// Checker for the masked bucket hash table: mirrors the table contents and compares each reply.
`timescale 1ns / 1ps

module table_checker #(
  parameter int MAX_INDEX_BITS = 8,
  parameter int WAYS           = 4,
  parameter int VALUE_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] lookup_key,
  input  logic [31:0] store_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        found,
  input  logic [31:0] read_value,
  input  logic        overflow,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          mismatches,
  output int          pending,
  output int          request_count,
  output int          hit_count,
  output int          overflow_count,
  output int          clear_count
);

  localparam int SLOTS = (1 << MAX_INDEX_BITS) * WAYS;
  localparam logic [63:0] VALUE_MASK =
    (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        overflow;
  } table_reply_t;

  logic         slot_valid [SLOTS];
  logic [31:0]  slot_key   [SLOTS];
  logic [63:0]  slot_value [SLOTS];
  logic [3:0]   index_width;
  table_reply_t replies_due [$];

  task automatic apply_request(input logic [1:0] act, input logic [31:0] key,
                               input logic [31:0] data, output table_reply_t reply);
    int bits;
    int base;
    int hit_way;
    int free_way;
    bits = index_width;
    if (bits < 1) bits = 1;
    if (bits > MAX_INDEX_BITS) bits = MAX_INDEX_BITS;
    base = int'(key & ((32'd1 << bits) - 32'd1)) * WAYS;
    hit_way = -1;
    free_way = -1;
    reply = '0;
    if (act == mbht_pkg::ACT_CLEAR) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      clear_count++;
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (slot_valid[base + w]) begin
          if (hit_way < 0 && slot_key[base + w] == key) hit_way = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      if (hit_way >= 0) begin
        reply.found = 1'b1;
        hit_count++;
      end
      case (act)
        mbht_pkg::ACT_GET: begin
          if (hit_way >= 0) reply.read_value = slot_value[base + hit_way][31:0];
        end
        mbht_pkg::ACT_PUT: begin
          if (hit_way >= 0) begin
            slot_value[base + hit_way] = {32'd0, data} & VALUE_MASK;
          end else if (free_way >= 0) begin
            slot_valid[base + free_way] = 1'b1;
            slot_key[base + free_way] = key;
            slot_value[base + free_way] = {32'd0, data} & VALUE_MASK;
          end else begin
            reply.overflow = 1'b1;
            overflow_count++;
          end
        end
        default: begin
          if (hit_way >= 0) slot_valid[base + hit_way] = 1'b0;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    table_reply_t due;
    if (rst) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      index_width = mbht_pkg::INDEX_BITS_RESET;
      replies_due.delete();
    end else begin
      // The reply leaving now belongs to an older transaction, so check before pushing.
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("reply with no request outstanding");
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          if (found !== due.found) begin
            $error("found: expected %0b, got %0b", due.found, found);
            mismatches++;
          end
          if (read_value !== due.read_value) begin
            $error("read_value: expected %08h, got %08h", due.read_value, read_value);
            mismatches++;
          end
          if (overflow !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, overflow);
            mismatches++;
          end
        end
      end
      // A request taken at the same edge as a width write still sees the old width.
      if (in_valid && in_ready) begin
        apply_request(action, lookup_key, store_value, due);
        replies_due.push_back(due);
        request_count++;
      end
      if (cfg_valid && cfg_ready) index_width = cfg_data;
    end
    pending = replies_due.size();
  end

endmodule

/* test/testbench.sv */
// Top of the hash table testbench: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_INDEX_BITS  = 8;
  localparam int WAYS            = 4;
  localparam int VALUE_BITS      = 32;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int KEY_POOL_SIZE   = 14;
  localparam int DRAIN_CYCLES    = 3 * (WAYS + 2);
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_A_START    = 1500;
  localparam int HOLD_B_START    = 9000;
  localparam int HOLD_LENGTH     = 400;
  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] lookup_key;
  logic [31:0] store_value;
  logic        out_valid;
  logic        out_ready;
  logic        found;
  logic [31:0] read_value;
  logic        overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  int mismatches;
  int pending;
  int request_count;
  int hit_count;
  int overflow_count;
  int clear_count;
  int cycle_count;
  int burst_left;

  logic [3:0]  phase_widths [8] = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd8, 4'd5, 4'd2, 4'd12};
  logic [7:0]  bucket_lows  [3] = '{8'h00, 8'h5A, 8'hFF};
  logic [31:0] key_pool [KEY_POOL_SIZE];

  masked_bucket_hash_table #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .WAYS(WAYS),
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .lookup_key(lookup_key), .store_value(store_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .read_value(read_value), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  table_checker #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .WAYS(WAYS),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .lookup_key(lookup_key), .store_value(store_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .read_value(read_value), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .request_count(request_count),
    .hit_count(hit_count), .overflow_count(overflow_count), .clear_count(clear_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one request; valid may drop for a random gap between bursts, and stays high inside a burst.
  task automatic send_request(input logic [1:0] act, input logic [31:0] key,
                              input logic [31:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    lookup_key <= key;
    store_value <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_request();
    int pick;
    logic [1:0]  act;
    logic [31:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 36) act = mbht_pkg::ACT_GET;
    else if (pick < 72) act = mbht_pkg::ACT_PUT;
    else if (pick < 97) act = mbht_pkg::ACT_DEL;
    else act = mbht_pkg::ACT_CLEAR;
    key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                       : $urandom();
    send_request(act, key, $urandom());
  endtask

  // Drop valid and wait until every reply is back and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_index_width(input logic [3:0] width);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= width;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: changing stall patterns, plus two long hold-offs to back up the input.
  initial begin
    int rx_cycle;
    int mode;
    int mode_left;
    out_ready = 1'b0;
    rx_cycle = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if ((rx_cycle >= HOLD_A_START && rx_cycle < HOLD_A_START + HOLD_LENGTH) ||
          (rx_cycle >= HOLD_B_START && rx_cycle < HOLD_B_START + HOLD_LENGTH)) begin
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= (rx_cycle % 3 != 0);
          default: out_ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    burst_left = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = mbht_pkg::ACT_GET;
    lookup_key = '0;
    store_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, key extremes, full bucket, overwrite, free and reuse, clear.
    send_request(mbht_pkg::ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(mbht_pkg::ACT_PUT, KEY_MIN, 32'hFFFF_FFFF);
    send_request(mbht_pkg::ACT_PUT, KEY_MAX, 32'h0000_0000);
    send_request(mbht_pkg::ACT_GET, KEY_MIN, 32'h0000_0000);
    send_request(mbht_pkg::ACT_GET, KEY_MAX, 32'hA5A5_A5A5);
    send_request(mbht_pkg::ACT_PUT, 32'h0000_0100, 32'h1111_1111);
    send_request(mbht_pkg::ACT_PUT, 32'h0000_0200, 32'h2222_2222);
    send_request(mbht_pkg::ACT_PUT, 32'h0000_0300, 32'h3333_3333);
    send_request(mbht_pkg::ACT_PUT, 32'hFFFF_FF00, 32'h4444_4444);
    send_request(mbht_pkg::ACT_PUT, 32'h0000_0100, 32'h5555_5555);
    send_request(mbht_pkg::ACT_GET, 32'h0000_0100, 32'h0000_0000);
    send_request(mbht_pkg::ACT_DEL, 32'h0000_0200, 32'hFFFF_FFFF);
    send_request(mbht_pkg::ACT_DEL, 32'h0000_0200, 32'h0000_0000);
    send_request(mbht_pkg::ACT_PUT, 32'hFFFF_FF00, 32'h6666_6666);
    send_request(mbht_pkg::ACT_GET, 32'hFFFF_FF00, 32'h0000_0000);
    send_request(mbht_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h8000_0001);
    send_request(mbht_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(mbht_pkg::ACT_DEL, 32'h7FFF_FFFE, 32'h0000_0000);
    send_request(mbht_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(mbht_pkg::ACT_GET, KEY_MIN, 32'h0000_0000);
    send_request(mbht_pkg::ACT_PUT, KEY_MIN, 32'h7FFF_FFFF);

    // Random phases; entries are kept across width changes on purpose.
    foreach (phase_widths[p]) begin
      settle();
      write_index_width(phase_widths[p]);
      foreach (key_pool[k]) begin
        key_pool[k] = ($urandom() & 32'hFFFF_FF00) | bucket_lows[$urandom_range(0, 2)];
      end
      repeat (ITEMS_PER_PHASE) send_random_request();
    end
    settle();

    $display("ran %0d requests over %0d index width phases, widths 0, 1, 8 and 15 among them",
             request_count, $size(phase_widths) + 1);
    $display("hits %0d, bucket overflows %0d, clears %0d",
             hit_count, overflow_count, clear_count);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mbht_pkg.sv
hdl/mbht_ram.sv
hdl/masked_bucket_hash_table.sv
test/table_checker.sv
test/testbench.sv
